// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is high
`define FFBA_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds across reset
`define FFBA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// shared constants and types of the first-fit block allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  // busy map organization: one memory word holds this many block bits
  localparam int WORD_W = 16;
  localparam int LOG_W  = 4;

  // pool size default
  localparam int MAX_BLOCKS_DEF = 256;

  // request and result field widths
  localparam int BYTES_W  = 24;
  localparam int BSIZE_W  = 16;
  localparam int BCOUNT_W = 9;
  localparam int RSTART_W = 8;
  localparam int RLEN_W   = 9;
  localparam int START_W  = 8;
  localparam int OFFS_W   = 24;

  // stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  // quotient bits kept by the block-count divider
  localparam int QUOT_W = 10;

  // configuration register reset values
  localparam logic [BSIZE_W-1:0]  BLOCK_SIZE_RST  = 16'd64;
  localparam logic [BCOUNT_W-1:0] BLOCK_COUNT_RST = 9'd256;

  // configuration register indexes
  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  // request kinds
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // divider status toward the controller
  typedef struct packed {
    logic              done;
    logic              over;
    logic [QUOT_W-1:0] need;
  } div_res_t;

  // word scan result toward the controller
  typedef struct packed {
    logic              hit;
    logic [LOG_W-1:0]  pos;
    logic [QUOT_W-1:0] run_out;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== src/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// generic simple dual-port ram, one write port, registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/ffba_div.sv =====
// ----------------------------------------------------------------------------
// ffba_div
// restoring divider giving the rounded-up block count of a byte request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffba_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [ffba_pkg::BYTES_W-1:0]    dividend,
  input  logic [ffba_pkg::BSIZE_W-1:0]    divisor,
  output ffba_pkg::div_res_t              res
);

  localparam int SH_W = ffba_pkg::BYTES_W + 1;

  logic [ffba_pkg::BYTES_W-1:0] rem;
  logic [ffba_pkg::QUOT_W-1:0]  quot;
  logic [3:0]                   k;
  logic                         busy;
  logic                         done;
  logic [SH_W-1:0]              dsh;
  logic                         ge;

  // one quotient bit a cycle, highest first
  assign dsh = SH_W'(divisor) << k;
  assign ge  = {1'b0, rem} >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rem  <= dividend;
        quot <= '0;
        k    <= 4'(ffba_pkg::QUOT_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dsh[ffba_pkg::BYTES_W-1:0];
        end
        quot[k] <= ge;
        if (k == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - 4'd1;
        end
      end
    end
  end

  // top quotient bit set means at least 512 blocks, more than any pool
  assign res.done = done;
  assign res.over = quot[ffba_pkg::QUOT_W-1];
  assign res.need = quot + ffba_pkg::QUOT_W'(|rem);

endmodule

`default_nettype wire

// ===== src/ffba_scan.sv =====
// ----------------------------------------------------------------------------
// ffba_scan
// evaluates one busy map word against the free run carried in from below
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffba_scan #(
  parameter int BI_W = 10
) (
  input  logic [ffba_pkg::WORD_W-1:0]   word,
  input  logic [BI_W-1:0]               base,
  input  logic [ffba_pkg::BCOUNT_W-1:0] pool,
  input  logic [ffba_pkg::QUOT_W-1:0]   need,
  input  logic [ffba_pkg::QUOT_W-1:0]   carry,
  output ffba_pkg::scan_res_t           res
);

  localparam int W = ffba_pkg::WORD_W;
  localparam int L = ffba_pkg::LOG_W;
  localparam int Q = ffba_pkg::QUOT_W;

  logic [W-1:0]   busy;
  logic [Q-1:0]   run [W];
  logic [W-1:0]   hit;
  logic           found;
  logic [L-1:0]   last_busy;

  always_comb begin
    // blocks beyond the pool count as busy
    for (int j = 0; j < W; j++) begin
      busy[j] = word[j] || !({base[BI_W-1:L], L'(j)} < BI_W'(pool));
    end
    // free run ending at each bit: from the nearest busy bit below, or the carry
    for (int j = 0; j < W; j++) begin
      found     = 1'b0;
      last_busy = '0;
      for (int i = 0; i < W; i++) begin
        if (i <= j && busy[i]) begin
          found     = 1'b1;
          last_busy = L'(i);
        end
      end
      if (busy[j]) begin
        run[j] = '0;
      end else if (found) begin
        run[j] = Q'(j) - Q'(last_busy);
      end else begin
        run[j] = carry + Q'(j + 1);
      end
      hit[j] = !busy[j] && (run[j] >= need);
    end
    // lowest bit that completes the run
    res.hit = 1'b0;
    res.pos = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        res.hit = 1'b1;
        res.pos = L'(j);
      end
    end
    res.run_out = run[W-1];
  end

endmodule

`default_nettype wire

// ===== src/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit allocator of contiguous block runs over a word-organized busy map
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake                    content
//   s_axis    in   s_axis_tvalid/s_axis_tready  tuser: func; tdata: request_bytes,
//                                               release_start, release_length
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata: granted, start_block,
//                                               byte_offset
//   cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// one request at a time. an allocate runs the divider, then one busy map
// read per 16-block word scanned, then the byte offset multiply and one
// read-modify-write per word marked; a failed scan or a request refused
// after the division goes to the result without marking. a release does one
// read-modify-write per word cleared; a zero-byte allocate or one with block
// size zero goes straight to the result. the single read port of the busy
// map sets the scan and mark speed.
// after reset a clearing pass zeroes every map word, with s_axis_tready low.
// a finished result waits in the output register while the next request is
// taken; a result still stalled at the end of the next request holds the
// block until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [23:0] request_bytes, [31:24] release_start, [40:32] release_length
  input  logic [ffba_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [0] func
  input  logic                               s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] granted, [8:1] start_block, [32:9] byte_offset
  output logic [ffba_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [ffba_pkg::BSIZE_W-1:0]       cfg_data
);

  localparam int W        = ffba_pkg::WORD_W;
  localparam int L        = ffba_pkg::LOG_W;
  localparam int Q        = ffba_pkg::QUOT_W;
  localparam int WORDS    = (MAX_BLOCKS + W - 1) / W;
  localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WC_W     = (AW > 6) ? AW : 6;
  localparam int BI_W     = WC_W + L;
  localparam int POOL_CAP = (MAX_BLOCKS > 511) ? 511 : MAX_BLOCKS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_MULT,
    ST_SWEEP,
    ST_RESP
  } state_t;

  state_t state;

  // configuration registers
  logic [ffba_pkg::BSIZE_W-1:0]  block_size;
  logic [ffba_pkg::BCOUNT_W-1:0] block_count;

  // sequencing registers
  logic [WC_W-1:0] rd_w;      // next word to read
  logic [WC_W-1:0] proc_w;    // word whose data is on the ram output
  logic            rd_vld;    // ram output holds word proc_w
  logic [WC_W-1:0] last_w;    // last word of the current pass
  logic [Q-1:0]    carry;     // free run reaching the top of the words below
  logic [Q-1:0]    need;
  logic [BI_W-1:0] lo;        // run to mark or clear, hi exclusive
  logic [BI_W-1:0] hi;
  logic            set_bits;
  logic [BI_W-1:0] start;
  logic            div_go;

  // pending and presented result
  logic                          pend_ok;
  logic [ffba_pkg::START_W-1:0]  pend_start;
  logic [ffba_pkg::OFFS_W-1:0]   pend_off;
  logic                          out_vld;
  logic                          res_ok;
  logic [ffba_pkg::START_W-1:0]  res_start;
  logic [ffba_pkg::OFFS_W-1:0]   res_off;

  // request fields
  logic                           in_func;
  logic [ffba_pkg::BYTES_W-1:0]   req_bytes;
  logic [ffba_pkg::RSTART_W-1:0]  rel_start;
  logic [ffba_pkg::RLEN_W-1:0]    rel_len;
  logic                           in_acc;
  logic [ffba_pkg::BYTES_W-1:0]   div_bytes;  // byte count held for the divider

  logic [ffba_pkg::BCOUNT_W-1:0]  pool;
  logic [ffba_pkg::BCOUNT_W:0]    rel_end;
  logic [BI_W-1:0]                rel_hi;
  logic [WC_W-1:0]                pool_last;
  logic [BI_W-1:0]                base;
  logic [BI_W-1:0]                hit_start;
  logic [BI_W-1:0]                alloc_hi;
  logic [ffba_pkg::BSIZE_W+8:0]   prod;
  logic                           issue;
  logic [W-1:0]                   mask;

  // busy map ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic [W-1:0]  ram_rdata;

  ffba_pkg::div_res_t  div_res;
  ffba_pkg::scan_res_t scan_res;

  assign in_func   = s_axis_tuser;
  assign req_bytes = s_axis_tdata[23:0];
  assign rel_start = s_axis_tdata[31:24];
  assign rel_len   = s_axis_tdata[40:32];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {7'd0, res_off, res_start, res_ok};

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size  <= ffba_pkg::BLOCK_SIZE_RST;
      block_count <= ffba_pkg::BLOCK_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ffba_pkg::REG_BLOCK_SIZE:  block_size  <= cfg_data;
        ffba_pkg::REG_BLOCK_COUNT: block_count <= cfg_data[ffba_pkg::BCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- datapath
  // pool is the block count clipped to the map size, and at most 511
  assign pool = (block_count > ffba_pkg::BCOUNT_W'(POOL_CAP)) ?
                ffba_pkg::BCOUNT_W'(POOL_CAP) : block_count;

  // release end clipped at the pool end
  assign rel_end = (ffba_pkg::BCOUNT_W + 1)'(rel_start) + (ffba_pkg::BCOUNT_W + 1)'(rel_len);
  assign rel_hi  = (rel_end > (ffba_pkg::BCOUNT_W + 1)'(pool)) ? BI_W'(pool) : BI_W'(rel_end);

  assign pool_last = WC_W'((BI_W'(pool) - BI_W'(1)) >> L);

  // run start once the scan finds its end
  assign base      = {proc_w, L'(0)};
  assign hit_start = base + BI_W'(scan_res.pos) + BI_W'(1) - BI_W'(need);
  assign alloc_hi  = start + BI_W'(need);

  // start is always below 511, so nine bits cover it
  assign prod = start[8:0] * block_size;

  assign issue = (rd_w <= last_w);

  // bits of word proc_w that fall in [lo, hi)
  always_comb begin
    for (int j = 0; j < W; j++) begin
      mask[j] = ({proc_w, L'(j)} >= lo) && ({proc_w, L'(j)} < hi);
    end
  end

  ffba_scan #(.BI_W(BI_W)) u_scan (
    .word  (ram_rdata),
    .base  (base),
    .pool  (pool),
    .need  (need),
    .carry (carry),
    .res   (scan_res)
  );

  ffba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_bytes),
    .divisor  (block_size),
    .res      (div_res)
  );

  // clearing pass writes zeros; sweeps write back the modified word
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = proc_w[AW-1:0];
    ram_wdata = set_bits ? (ram_rdata | mask) : (ram_rdata & ~mask);
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = rd_w[AW-1:0];
      ram_wdata = '0;
    end else if (state == ST_SWEEP) begin
      ram_we    = rd_vld;
    end
  end

  ffba_ram #(.WIDTH(W), .DEPTH(WORDS), .ADDR_W(AW)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_w[AW-1:0]),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------ controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      rd_w    <= '0;
      rd_vld  <= 1'b0;
      div_go  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (out_vld && m_axis_tready) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (rd_w[AW-1:0] == AW'(WORDS - 1)) begin
            state <= ST_IDLE;
          end else begin
            rd_w <= rd_w + WC_W'(1);
          end
        end

        ST_IDLE: begin
          if (in_acc) begin
            pend_start <= '0;
            pend_off   <= '0;
            rd_vld     <= 1'b0;
            div_bytes  <= req_bytes;
            if (in_func == ffba_pkg::FUNC_RELEASE) begin
              pend_ok  <= 1'b1;
              set_bits <= 1'b0;
              lo       <= BI_W'(rel_start);
              hi       <= rel_hi;
              rd_w     <= WC_W'(BI_W'(rel_start) >> L);
              last_w   <= WC_W'((rel_hi - BI_W'(1)) >> L);
              // start at or past the clipped end clears nothing
              state    <= (BI_W'(rel_start) >= rel_hi) ? ST_RESP : ST_SWEEP;
            end else if (req_bytes == '0) begin
              pend_ok <= 1'b1;
              state   <= ST_RESP;
            end else if (block_size == '0) begin
              pend_ok <= 1'b0;
              state   <= ST_RESP;
            end else begin
              div_go <= 1'b1;
              state  <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          if (div_res.done) begin
            if (div_res.over || (div_res.need > Q'(pool))) begin
              pend_ok <= 1'b0;
              state   <= ST_RESP;
            end else begin
              need   <= div_res.need;
              carry  <= '0;
              rd_w   <= '0;
              rd_vld <= 1'b0;
              last_w <= pool_last;
              state  <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          rd_vld <= issue;
          proc_w <= rd_w;
          if (issue) begin
            rd_w <= rd_w + WC_W'(1);
          end
          if (rd_vld) begin
            if (scan_res.hit) begin
              start <= hit_start;
              state <= ST_MULT;
            end else if (proc_w == last_w) begin
              pend_ok <= 1'b0;
              state   <= ST_RESP;
            end else begin
              carry <= scan_res.run_out;
            end
          end
        end

        ST_MULT: begin
          pend_ok    <= 1'b1;
          pend_start <= start[ffba_pkg::START_W-1:0];
          pend_off   <= prod[ffba_pkg::OFFS_W-1:0];
          set_bits   <= 1'b1;
          lo         <= start;
          hi         <= alloc_hi;
          rd_w       <= WC_W'(start >> L);
          last_w     <= WC_W'((alloc_hi - BI_W'(1)) >> L);
          rd_vld     <= 1'b0;
          state      <= ST_SWEEP;
        end

        ST_SWEEP: begin
          // read one word ahead of the write-back, never the same word
          rd_vld <= issue;
          proc_w <= rd_w;
          if (issue) begin
            rd_w <= rd_w + WC_W'(1);
          end
          if (rd_vld && (proc_w == last_w)) begin
            rd_vld <= 1'b0;
            state  <= ST_RESP;
          end
        end

        ST_RESP: begin
          if (!out_vld || m_axis_tready) begin
            out_vld   <= 1'b1;
            res_ok    <= pend_ok;
            res_start <= pend_start;
            res_off   <= pend_off;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// ffba_checker
// port-level checks of the first-fit block allocator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ffba_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [ffba_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // map clearing pass follows reset
  `FFBA_ASSERT_ALWAYS(a_clear_after_reset, clk, rst |=> !s_axis_tready, "request taken during map clear")

  // one request at a time
  `FFBA_ASSERT(a_one_at_a_time, clk, rst, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "request taken while busy")

  // refused allocate carries no position
  `FFBA_ASSERT(a_fail_zero, clk, rst, (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[32:1] == 32'd0), "failed result with nonzero position")

  // stalled result holds
  `FFBA_ASSERT(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
